FILE: design/wss_pkg.sv
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants of the wildcard signature scanner
// Holds the signature table, the window length, the address width and the
// control bundles passed between the match cells, the tally and the top.
// ----------------------------------------------------------------------------
package wss_pkg;

  // Window length and internal address width
  localparam int PATTERN_LEN = 54;
  localparam int ADDR_BITS   = 32;
  localparam int SIG_MAX     = 64;

  // Match counter saturates here
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // Signature entry: bit 8 set marks a wildcard
  localparam logic [8:0] SIG_ANY = 9'h100;

  localparam logic [8:0] SIG_TABLE [SIG_MAX] = '{
    9'h055, 9'h08B, 9'h0EC, 9'h081, 9'h0EC, 9'h094, 9'h000, 9'h000,
    9'h000, 9'h0C6, 9'h045, 9'h0FF, 9'h001, 9'h0E8,
    SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY,
    9'h089, 9'h085, 9'h078, 9'h0FF, 9'h0FF, 9'h0FF, 9'h068,
    SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY,
    9'h0E8,
    SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY,
    9'h083, 9'h0C4, 9'h004, 9'h00F, 9'h0B6, 9'h005,
    SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY,
    9'h085, 9'h0C0, 9'h00F, 9'h084,
    SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY,
    9'h06A, 9'h02E,
    SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY, SIG_ANY,
    SIG_ANY, SIG_ANY
  };

  // One signature position as seen by a cell
  typedef struct packed {
    logic       any;
    logic [7:0] value;
  } sig_entry_t;

  // Per-transfer control broadcast to the cells
  typedef struct packed {
    logic advance;   // input transfer this cycle
    logic clear;     // section or scan ends with this byte
  } cell_ctl_t;

  // Per-transfer control for the tally
  typedef struct packed {
    logic advance;
    logic scan_end;
  } tally_ctl_t;

  // Scan-wide match bookkeeping
  typedef struct packed {
    logic [7:0]           count;
    logic                 have_first;
    logic [ADDR_BITS-1:0] first;
  } tally_t;

endpackage

FILE: design/wildcard_signature_scanner.sv
// ----------------------------------------------------------------------------
// wildcard_signature_scanner: streaming wildcard byte-signature matcher
// Matches a fixed signature with wildcards against a byte stream, one byte
// per cycle while not stalled, through a chain of single-flag match cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one code byte per transfer with its
//   address and the section_last / scan_last marks.
//   Result channel (out_valid / out_stall): exactly one result per input
//   byte, in order.
//   The result of a byte is valid the cycle after its transfer. The block
//   takes one byte per cycle while out_stall is low; each cell compares the new
//   byte against its signature entry and passes its flag on, so the window
//   check costs one compare and an AND per cell.
//   A stalled result stays in the output register; in_stall rises only while
//   that register is full and stalled, so inputs keep flowing as long as the
//   receiver takes a result each cycle.
//   Reset empties the window, the match count and the first address. After a
//   section_last byte the window empties; after a scan_last byte the whole
//   scan state returns to its reset values.
// ----------------------------------------------------------------------------
module wildcard_signature_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_byte_address,
  input  logic        in_section_last,
  input  logic        in_scan_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match_here,
  output logic [31:0] out_match_start,
  output logic [7:0]  out_match_total,
  output logic        out_scan_done,
  output logic        out_scan_unique,
  output logic [31:0] out_first_address
);

  localparam int LEN = wss_pkg::PATTERN_LEN;
  localparam int AW  = wss_pkg::ADDR_BITS;

  logic                 in_xfer;
  wss_pkg::cell_ctl_t   cell_ctl;
  wss_pkg::tally_ctl_t  tally_ctl;
  logic [LEN-1:0]       hit_now;
  logic [LEN-1:0]       hit_r;
  logic                 hit;
  logic [AW-1:0]        addr_ext;
  logic [AW-1:0]        start;
  wss_pkg::tally_t      upd;
  wss_pkg::tally_t      tally_r;

  logic        out_valid_r,  out_valid_nxt;
  logic        match_here_r, match_here_nxt;
  logic [31:0] match_start_r, match_start_nxt;
  logic [7:0]  match_total_r, match_total_nxt;
  logic        scan_done_r,  scan_done_nxt;
  logic        scan_unique_r, scan_unique_nxt;
  logic [31:0] first_addr_r, first_addr_nxt;

  // Accept while the output register is free or being drained
  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign cell_ctl.advance  = in_xfer;
  assign cell_ctl.clear    = in_section_last || in_scan_last;
  assign tally_ctl.advance = in_xfer;
  assign tally_ctl.scan_end = in_scan_last;

  // Match chain: one cell per signature position
  for (genvar k = 0; k < LEN; k++) begin : g_cell
    wss_pkg::sig_entry_t sig;
    logic                prev_hit;

    assign sig.any   = wss_pkg::SIG_TABLE[k][8];
    assign sig.value = wss_pkg::SIG_TABLE[k][7:0];

    if (k == 0) begin : g_head
      assign prev_hit = 1'b1;
    end else begin : g_link
      assign prev_hit = hit_r[k-1];
    end

    wss_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .sig       (sig),
      .data_byte (in_data_byte),
      .prev_hit  (prev_hit),
      .hit_now   (hit_now[k]),
      .hit_r     (hit_r[k])
    );
  end

  assign hit = hit_now[LEN-1];

  // Start address of a match ending at this byte, wrapping
  assign addr_ext = AW'(in_byte_address);
  assign start    = addr_ext - AW'(LEN - 1);

  wss_tally u_tally (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (tally_ctl),
    .hit     (hit),
    .start   (start),
    .upd     (upd),
    .tally_r (tally_r)
  );

  // Build the result of this byte
  always_comb begin
    match_here_nxt  = match_here_r;
    match_start_nxt = match_start_r;
    match_total_nxt = match_total_r;
    scan_done_nxt   = scan_done_r;
    scan_unique_nxt = scan_unique_r;
    first_addr_nxt  = first_addr_r;
    if (in_xfer) begin
      match_here_nxt  = hit;
      match_start_nxt = hit ? 32'(start) : 32'd0;
      match_total_nxt = upd.count;
      scan_done_nxt   = in_scan_last;
      scan_unique_nxt = in_scan_last && (upd.count == 8'd1);
      first_addr_nxt  = upd.have_first ? 32'(upd.first) : 32'd0;
    end
  end

  // Hold a stalled result, load on transfer, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_here_r  <= match_here_nxt;
    match_start_r <= match_start_nxt;
    match_total_r <= match_total_nxt;
    scan_done_r   <= scan_done_nxt;
    scan_unique_r <= scan_unique_nxt;
    first_addr_r  <= first_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_match_here    = match_here_r;
  assign out_match_start   = match_start_r;
  assign out_match_total   = match_total_r;
  assign out_scan_done     = scan_done_r;
  assign out_scan_unique   = scan_unique_r;
  assign out_first_address = first_addr_r;

  // A unique verdict only comes with scan end and a count of one
  a_unique_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_scan_unique) |-> (out_scan_done && out_match_total == 8'd1))
    else $error("unique verdict without a single match at scan end");

  // A match always leaves a nonzero count and, unless the scan just ended,
  // a recorded first match
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_match_here) |->
      (out_match_total != 8'd0 && (out_scan_done || tally_r.have_first)))
    else $error("match reported without count or first address");

  // Scan end returns the tally and the chain to their reset state
  a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_scan_last) |=> (tally_r == '0 && hit_r == '0))
    else $error("scan state not cleared after last byte");

  // Without a match the start address reads zero
  a_no_match_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_match_here) |-> (out_match_start == 32'd0))
    else $error("start address set without a match");

endmodule

FILE: design/wss_cell.sv
// ----------------------------------------------------------------------------
// wss_cell: one position of the match chain
// Holds a flag meaning "the bytes of this section seen so far end with
// signature entries 0..k". The flag moves one cell to the right per byte.
// ----------------------------------------------------------------------------
module wss_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wss_pkg::cell_ctl_t  ctl,
  input  wss_pkg::sig_entry_t sig,
  input  logic [7:0]          data_byte,
  input  logic                prev_hit,
  output logic                hit_now,
  output logic                hit_r
);

  logic hit_nxt;

  // Extend the left neighbor's partial match by this byte
  assign hit_now = prev_hit && (sig.any || (data_byte == sig.value));

  // Advance on a transfer, drop at a section boundary
  always_comb begin
    hit_nxt = hit_r;
    if (ctl.advance) begin
      hit_nxt = ctl.clear ? 1'b0 : hit_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

endmodule

FILE: design/wss_tally.sv
// ----------------------------------------------------------------------------
// wss_tally: match counter and first-match address
// Counts matches with saturation, records the first start address and
// returns to zero after the last byte of a scan.
// ----------------------------------------------------------------------------
module wss_tally (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wss_pkg::tally_ctl_t                 ctl,
  input  logic                                hit,
  input  logic [wss_pkg::ADDR_BITS-1:0]       start,
  output wss_pkg::tally_t                     upd,
  output wss_pkg::tally_t                     tally_r
);

  wss_pkg::tally_t tally_nxt;

  // Fold this byte's match into the bookkeeping
  always_comb begin
    upd = tally_r;
    if (hit) begin
      if (tally_r.count != wss_pkg::COUNT_MAX) begin
        upd.count = tally_r.count + 8'd1;
      end
      if (!tally_r.have_first) begin
        upd.have_first = 1'b1;
        upd.first      = start;
      end
    end
  end

  // Hold, advance, or clear at scan end
  always_comb begin
    tally_nxt = tally_r;
    if (ctl.advance) begin
      tally_nxt = ctl.scan_end ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tally_r <= '0;
    end else begin
      tally_r <= tally_nxt;
    end
  end

endmodule
